FILE: hw/rtl/rpn_stack_calculator_core_assert.svh
// assertion macros shared by the rpn calculator rtl
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef RPN_STACK_CALCULATOR_CORE_ASSERT_SVH
`define RPN_STACK_CALCULATOR_CORE_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define RPN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rpn_pkg.sv
// shared types, codes and saturation helpers for the rpn calculator
// used by rpn_ctrl, rpn_div, rpn_dpath and rpn_stack_calculator_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  // command codes on the func field
  typedef enum logic [2:0] {
    FN_PUSH  = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_MUL   = 3'd3,
    FN_DIV   = 3'd4,
    FN_PRINT = 3'd5
  } func_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_B,
    ST_GET_B,
    ST_POP_A,
    ST_GET_A,
    ST_EXEC,
    ST_MUL_RND,
    ST_DIV_RUN,
    ST_PUSH,
    ST_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_POP,
    DP_TAKE_B,
    DP_TAKE_A,
    DP_ADD,
    DP_SUB,
    DP_MUL,
    DP_MUL_RND,
    DP_DIV_START,
    DP_DIV_TAKE,
    DP_PUSH,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   set_dz;   // flag divide by zero for this command
    logic   print;    // result carries the popped value
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;     // divisor just popped is zero
    logic div_busy;   // divider still iterating
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // magnitude of a two's complement word, min value maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  // apply sign to a magnitude and clamp to the q16.16 range
  function automatic logic [31:0] sat_mag(input logic neg, input logic [48:0] m);
    logic [31:0] res;
    if (!neg) begin
      res = (m > {17'd0, Q_MAX}) ? Q_MAX : m[31:0];
    end else begin
      res = (m > {17'd0, Q_MIN}) ? Q_MIN : (~m[31:0] + 32'd1);
    end
    sat_mag = res;
  endfunction

  // clamp a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat_sum(input logic [32:0] s);
    logic [31:0] res;
    if (s[32] != s[31]) begin
      res = s[32] ? Q_MIN : Q_MAX;
    end else begin
      res = s[31:0];
    end
    sat_sum = res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rpn_ctrl.sv
// controller state machine of the rpn calculator
// sequences pops, arithmetic, push and result transfer; depends on rpn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          func,
  input  rpn_pkg::dp_status_t st,
  output rpn_pkg::dp_cmd_t    cmd
);
  import rpn_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [2:0]  op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command code held for the whole item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op <= func;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{op: DP_NOP, set_dz: 1'b0, print: 1'b0};
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = DP_LOAD;
          unique case (func) inside
            FN_PUSH:                                   state_next = ST_PUSH;
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_PRINT: state_next = ST_POP_B;
            default:                                   state_next = ST_DONE;
          endcase
        end
      end
      ST_POP_B: begin
        cmd.op     = DP_POP;
        state_next = ST_GET_B;
      end
      ST_GET_B: begin
        cmd.op = DP_TAKE_B;
        if (op == FN_PRINT) begin
          state_next = ST_DONE;
        end else if (op == FN_DIV && st.b_zero) begin
          cmd.set_dz = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_POP_A;
        end
      end
      ST_POP_A: begin
        cmd.op     = DP_POP;
        state_next = ST_GET_A;
      end
      ST_GET_A: begin
        cmd.op     = DP_TAKE_A;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op) inside
          FN_ADD: begin
            cmd.op     = DP_ADD;
            state_next = ST_PUSH;
          end
          FN_SUB: begin
            cmd.op     = DP_SUB;
            state_next = ST_PUSH;
          end
          FN_MUL: begin
            cmd.op     = DP_MUL;
            state_next = ST_MUL_RND;
          end
          FN_DIV: begin
            cmd.op     = DP_DIV_START;
            state_next = ST_DIV_RUN;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL_RND: begin
        cmd.op     = DP_MUL_RND;
        state_next = ST_PUSH;
      end
      ST_DIV_RUN: begin
        if (!st.div_busy) begin
          cmd.op     = DP_DIV_TAKE;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.op     = DP_PUSH;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd.op     = DP_EMIT;
          cmd.print  = (op == FN_PRINT);
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_div.sv
// iterative restoring divider for q16.16 magnitudes, one quotient bit per cycle
// quotient of (dividend << 16) / divisor with an overflow flag; depends on rpn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend_mag,
  input  logic [31:0] divisor_mag,
  output logic        busy,
  output logic [31:0] quotient,
  output logic        q_ovf
);
  import rpn_pkg::*;

  logic [31:0]          rem;
  logic [31:0]          work;   // dividend bits shift out, quotient bits shift in
  logic [31:0]          dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [32:0]          rem_sh;
  logic [32:0]          diff;
  logic                 fits;

  assign rem_sh   = {rem, work[31]};
  assign diff     = rem_sh - {1'b0, dsr};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper half of the dividend seeds the remainder
      rem   <= {16'd0, dividend_mag[31:16]};
      work  <= {dividend_mag[15:0], 16'd0};
      dsr   <= divisor_mag;
      q_ovf <= ({16'd0, dividend_mag[31:16]} >= divisor_mag);
    end else if (busy) begin
      rem  <= fits ? diff[31:0] : rem_sh[31:0];
      work <= {work[30:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_dpath.sv
// datapath of the rpn calculator: operand stack memory, stack pointer,
// operand and result registers, multiplier, divider and output register; depends on rpn_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_core_assert.svh"

module rpn_dpath #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  rpn_pkg::dp_cmd_t    cmd,
  output rpn_pkg::dp_status_t st,
  input  logic signed [31:0]  operand_value,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  printed_value,
  output logic                printed_valid,
  output logic                underflow_flag,
  output logic                overflow_flag,
  output logic                divide_by_zero_flag
);
  import rpn_pkg::*;

  localparam int SpW   = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SpW-1:0] SP_FULL = SpW'(STACK_DEPTH);
  localparam logic [SpW-1:0] SP_ONE  = SpW'(1);

  logic [31:0]    mem [STACK_DEPTH];
  logic [SpW-1:0] sp;
  logic [SpW-1:0] sp_m1;
  logic [31:0]    rdata;
  logic           pop_hit;
  logic [31:0]    a;
  logic [31:0]    b;
  logic [31:0]    res;
  logic [63:0]    prod;
  logic           under;
  logic           ovf;
  logic           dz;

  logic [31:0]    take_val;
  logic [31:0]    a_mag;
  logic [31:0]    b_mag;
  logic           neg;
  logic [63:0]    prod_rnd;
  logic           div_busy;
  logic [31:0]    div_q;
  logic           div_q_ovf;
  logic [48:0]    div_mag;
  logic           push_ok;

  assign sp_m1    = sp - SP_ONE;
  assign push_ok  = (sp != SP_FULL);
  assign take_val = pop_hit ? rdata : 32'd0;
  assign a_mag    = mag32(a);
  assign b_mag    = mag32(b);
  assign neg      = a[31] ^ b[31];
  assign prod_rnd = prod + 64'h8000;
  assign div_mag  = div_q_ovf ? 49'h1_0000_0000 : {17'd0, div_q};

  assign st.b_zero   = (take_val == 32'd0);
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid || !out_stall;

  rpn_div u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (cmd.op == DP_DIV_START),
    .dividend_mag (a_mag),
    .divisor_mag  (b_mag),
    .busy         (div_busy),
    .quotient     (div_q),
    .q_ovf        (div_q_ovf)
  );

  // stack storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PUSH && push_ok) begin
      mem[sp[AddrW-1:0]] <= res;
    end
    if (cmd.op == DP_POP) begin
      rdata <= mem[sp_m1[AddrW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == DP_POP && sp != '0) begin
        sp <= sp_m1;
      end else if (cmd.op == DP_PUSH && push_ok) begin
        sp <= sp + SP_ONE;
      end
      if (cmd.op == DP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // operands, results and flags
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        res   <= operand_value;
        under <= 1'b0;
        ovf   <= 1'b0;
        dz    <= 1'b0;
      end
      DP_POP: begin
        pop_hit <= (sp != '0);
        if (sp == '0) begin
          under <= 1'b1;
        end
      end
      DP_TAKE_B: begin
        b <= take_val;
        if (cmd.set_dz) begin
          dz <= 1'b1;
        end
      end
      DP_TAKE_A:    a    <= take_val;
      DP_ADD:       res  <= sat_sum({a[31], a} + {b[31], b});
      DP_SUB:       res  <= sat_sum({a[31], a} - {b[31], b});
      DP_MUL:       prod <= a_mag * b_mag;
      DP_MUL_RND:   res  <= sat_mag(neg, {1'b0, prod_rnd[63:16]});
      DP_DIV_TAKE:  res  <= sat_mag(neg, div_mag);
      DP_PUSH: begin
        if (!push_ok) begin
          ovf <= 1'b1;
        end
      end
      DP_EMIT: begin
        printed_value       <= cmd.print ? b : 32'd0;
        printed_valid       <= cmd.print;
        underflow_flag      <= under;
        overflow_flag       <= ovf;
        divide_by_zero_flag <= dz;
      end
      default: begin
      end
    endcase
  end

  `RPN_ASSERT_ALWAYS(a_sp_range, (sp <= SP_FULL), "stack pointer beyond stack depth")
  `RPN_ASSERT_NEXT(a_push_grows, (cmd.op == DP_PUSH && sp != SP_FULL), (sp == $past(sp) + SP_ONE), "stack pointer did not advance on push")
  `RPN_ASSERT_NEXT(a_empty_pop, (cmd.op == DP_POP && sp == '0), (under && sp == '0), "pop of empty stack not flagged")

endmodule

`default_nettype wire

FILE: hw/rtl/rpn_stack_calculator_core.sv
// Reverse polish calculator on a stack of signed q16.16 values. One input transfer
// carries one command (push, add, subtract, multiply, divide, pop and print) and
// produces exactly one result transfer with the printed value and the error flags.
// Commands run one at a time; the time from one acceptance to the next is set by
// the stack memory's registered read (a pop step and a take step per operand) and
// by the divider, which retires one quotient bit per cycle. A finished result sits
// in an output register, so the next command is accepted while the previous result
// is still stalled. The stack needs no clearing after reset.
// depends on rpn_pkg, rpn_ctrl, rpn_dpath and rpn_div
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = 128   // entries in the operand stack, 2 to 4096
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [31:0] operand_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] printed_value,
  output logic               printed_valid,
  output logic               underflow_flag,
  output logic               overflow_flag,
  output logic               divide_by_zero_flag
);
  import rpn_pkg::*;

  // command and status between the controller and the datapath
  dp_cmd_t    cmd;
  dp_status_t st;

  // controller: accepts a transfer only when idle and walks the pop, compute,
  // push and emit steps for that command
  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: stack memory, pointer, arithmetic units and result register
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .operand_value       (operand_value),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .printed_value       (printed_value),
    .printed_valid       (printed_valid),
    .underflow_flag      (underflow_flag),
    .overflow_flag       (overflow_flag),
    .divide_by_zero_flag (divide_by_zero_flag)
  );

endmodule

`default_nettype wire

FILE: tb/sv/rpn_stack_calculator_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for rpn_stack_calculator_core: directed and random command streams
// with random idling on both channels, checked against an in-bench stack calculator model
// depends on rpn_pkg and rpn_stack_calculator_core

module rpn_stack_calculator_core_test;
  import rpn_pkg::*;

  localparam int STACK_DEPTH = 128;
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the block up
  localparam int MAX_REPORTS = 40;   // cap on printed mismatch lines

  // command codes the block must treat as no-ops
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  localparam logic [31:0] ONE_Q     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE_Q = 32'hFFFF_0000;
  localparam logic [31:0] HALF_LSB  = 32'h0000_8000;

  typedef longint unsigned u64_t;

  // one expected result transfer
  typedef struct packed {
    logic [31:0] value;
    logic        shown;
    logic        under;
    logic        over;
    logic        div_zero;
  } calc_result_t;

  logic               clk;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [2:0]         func          = '0;
  logic signed [31:0] operand_value = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [31:0] printed_value;
  logic               printed_valid;
  logic               underflow_flag;
  logic               overflow_flag;
  logic               divide_by_zero_flag;

  rpn_stack_calculator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .operand_value      (operand_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .printed_value      (printed_value),
    .printed_valid      (printed_valid),
    .underflow_flag     (underflow_flag),
    .overflow_flag      (overflow_flag),
    .divide_by_zero_flag(divide_by_zero_flag)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // calculator model: operand stack, depth and per-command error flags
  // ---------------------------------------------------------------------------
  logic [31:0]  model_stack [STACK_DEPTH];
  int           model_depth = 0;
  logic         saw_empty_pop;
  logic         saw_full_push;
  calc_result_t awaited_results [$];
  int           mismatches = 0;

  // idling controls shared between the stimulus and the result drain
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  bit hold_request   = 1'b0;
  bit hold_active    = 1'b0;

  function automatic logic [31:0] model_pop();
    if (model_depth > 0) begin
      model_depth--;
      return model_stack[model_depth];
    end
    saw_empty_pop = 1'b1;  // empty pop yields zero
    return '0;
  endfunction

  function automatic void model_push(logic [31:0] v);
    if (model_depth < STACK_DEPTH) begin
      model_stack[model_depth] = v;
      model_depth++;
    end else begin
      saw_full_push = 1'b1;  // value dropped
    end
  endfunction

  // clamp a wide signed value into q16.16
  function automatic logic [31:0] clamp_q(longint s);
    if (s > longint'($signed(Q_MAX))) return Q_MAX;
    if (s < longint'($signed(Q_MIN))) return Q_MIN;
    return s[31:0];
  endfunction

  function automatic u64_t abs_q(logic [31:0] x);
    longint s;
    s = longint'($signed(x));
    return (s < 0) ? $unsigned(-s) : $unsigned(s);
  endfunction

  function automatic logic [31:0] signed_clamp(logic neg, u64_t m);
    longint s;
    s = $signed(m);
    return clamp_q(neg ? -s : s);
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic logic [31:0] q_product(logic [31:0] a, logic [31:0] b);
    u64_t p;
    p = abs_q(a) * abs_q(b);
    return signed_clamp(a[31] ^ b[31], (p + 64'h8000) >> 16);
  endfunction

  // quotient truncated toward zero
  function automatic logic [31:0] q_quotient(logic [31:0] a, logic [31:0] b);
    u64_t q;
    q = (abs_q(a) << 16) / abs_q(b);
    return signed_clamp(a[31] ^ b[31], q);
  endfunction

  function automatic calc_result_t apply_command(logic [2:0] fn, logic [31:0] val);
    calc_result_t res;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    res           = '0;
    saw_empty_pop = 1'b0;
    saw_full_push = 1'b0;
    case (fn)
      FN_PUSH: model_push(val);
      FN_ADD: begin
        rhs = model_pop();
        lhs = model_pop();
        model_push(clamp_q(longint'($signed(lhs)) + longint'($signed(rhs))));
      end
      FN_SUB: begin
        rhs = model_pop();
        lhs = model_pop();
        model_push(clamp_q(longint'($signed(lhs)) - longint'($signed(rhs))));
      end
      FN_MUL: begin
        rhs = model_pop();
        lhs = model_pop();
        model_push(q_product(lhs, rhs));
      end
      FN_DIV: begin
        rhs = model_pop();
        if (rhs == '0) begin
          // divisor consumed, first operand stays
          res.div_zero = 1'b1;
        end else begin
          lhs = model_pop();
          model_push(q_quotient(lhs, rhs));
        end
      end
      FN_PRINT: begin
        res.value = model_pop();
        res.shown = 1'b1;
      end
      default: ;  // reserved codes leave everything alone
    endcase
    res.under = saw_empty_pop;
    res.over  = saw_full_push;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, long hold on request, field-by-field check
  // ---------------------------------------------------------------------------
  initial begin : result_drain
    int span;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 99) < 35) begin
        // mostly short stalls, now and then a long one
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    calc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result transfer with none expected, expected nothing, actual %h",
                   $time, printed_value);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("printed_value", want.value, printed_value);
        compare_field("printed_valid", want.shown, printed_valid);
        compare_field("underflow_flag", want.under, underflow_flag);
        compare_field("overflow_flag", want.over, overflow_flag);
        compare_field("divide_by_zero_flag", want.div_zero, divide_by_zero_flag);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // mix of zero, the range limits, small numbers and full-width noise
  function automatic logic [31:0] pick_operand();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    if (r < 5) begin
      v = {16'($urandom_range(0, 7)), 16'($urandom)};
      return $urandom_range(0, 1) ? -v : v;
    end
    return $urandom;
  endfunction

  // keep the stack mostly fed so the arithmetic paths see real operands
  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (model_depth < 2 && r < 55) return FN_PUSH;
    if (r < 2) return r[0] ? FN_RSVD7 : FN_RSVD6;
    if (r < 38) return FN_PUSH;
    if (r < 48) return FN_ADD;
    if (r < 57) return FN_SUB;
    if (r < 67) return FN_MUL;
    if (r < 79) return FN_DIV;
    return FN_PRINT;
  endfunction

  // one command transfer; valid stays high afterwards so back-to-back items
  // need no extra edge
  task automatic issue_command(input logic [2:0] fn, input logic [31:0] val);
    int gap;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= fn;
    operand_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(apply_command(fn, val));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_stack();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    issue_command(FN_PRINT, $urandom);   // print on empty stack
    issue_command(FN_DIV, $urandom);     // divisor from empty stack is zero
    issue_command(FN_RSVD6, $urandom);
    issue_command(FN_RSVD7, $urandom);
    issue_command(FN_ADD, $urandom);     // both operands missing, pushes zero
    issue_command(FN_PUSH, 32'h0003_0000);
    issue_command(FN_SUB, $urandom);     // 0 - 3.0
    issue_command(FN_PRINT, $urandom);
    pause_until_drained();
  endtask

  task automatic test_saturation();
    issue_command(FN_PUSH, Q_MAX);
    issue_command(FN_PUSH, Q_MAX);
    issue_command(FN_ADD, $urandom);
    issue_command(FN_PRINT, $urandom);
    issue_command(FN_PUSH, Q_MIN);
    issue_command(FN_PUSH, Q_MAX);
    issue_command(FN_SUB, $urandom);
    issue_command(FN_PRINT, $urandom);
    pause_until_drained();
  endtask

  task automatic test_rounding_and_division();
    // negative half-lsb tie rounds away from zero
    issue_command(FN_PUSH, HALF_LSB);
    issue_command(FN_PUSH, 32'hFFFF_FFFF);
    issue_command(FN_MUL, $urandom);
    issue_command(FN_PRINT, $urandom);
    // most negative over -1.0 saturates
    issue_command(FN_PUSH, Q_MIN);
    issue_command(FN_PUSH, NEG_ONE_Q);
    issue_command(FN_DIV, $urandom);
    issue_command(FN_PRINT, $urandom);
    // zero divisor leaves the dividend on the stack
    issue_command(FN_PUSH, ONE_Q);
    issue_command(FN_PUSH, '0);
    issue_command(FN_DIV, $urandom);
    issue_command(FN_PRINT, $urandom);
    pause_until_drained();
  endtask

  task automatic test_full_stack();
    repeat (STACK_DEPTH) issue_command(FN_PUSH, pick_operand());
    repeat (3) issue_command(FN_PUSH, pick_operand());  // dropped pushes
    while (model_depth > 0) begin
      if ($urandom_range(0, 3) == 0)
        issue_command(FN_PRINT, $urandom);
      else
        issue_command(3'(FN_ADD + $urandom_range(0, 3)), $urandom);
    end
    issue_command(FN_PRINT, $urandom);
    pause_until_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  task automatic test_result_backpressure();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_request   = 1'b1;
    while (!hold_active) @(posedge clk);
    for (int i = 0; i < 24; i++)
      issue_command((i % 3 == 2) ? FN_PRINT : FN_PUSH, pick_operand());
    pause_until_drained();
  endtask

  task automatic test_random_mix(input int count, input bit idle);
    sender_idles   = idle;
    receiver_idles = idle;
    for (int i = 0; i < count; i++) begin
      if (idle && $urandom_range(0, 99) == 0) pause_until_drained();
      issue_command(pick_func(), pick_operand());
    end
    pause_until_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_stack();
    test_saturation();
    test_rounding_and_division();
    test_full_stack();
    test_result_backpressure();
    test_random_mix(300, 1'b1);
    test_random_mix(100, 1'b0);
    receiver_idles = 1'b0;
    // room for a stray late transfer; divide is the slowest command
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_dpath.sv
hw/rtl/rpn_stack_calculator_core.sv
tb/sv/rpn_stack_calculator_core_test.sv
